FILE: design/svm_pkg.sv
// Shared types and constants for the stack machine execution core.
// Holds opcodes, status codes, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none
package svm_pkg;

	localparam int MEM_WORDS = 16384;
	localparam int MEM_AW    = $clog2(MEM_WORDS);

	localparam logic [5:0] OP_LEA  = 6'd0;
	localparam logic [5:0] OP_IMM  = 6'd1;
	localparam logic [5:0] OP_JMP  = 6'd2;
	localparam logic [5:0] OP_CALL = 6'd3;
	localparam logic [5:0] OP_JZ   = 6'd4;
	localparam logic [5:0] OP_JNZ  = 6'd5;
	localparam logic [5:0] OP_ENT  = 6'd6;
	localparam logic [5:0] OP_ADJ  = 6'd7;
	localparam logic [5:0] OP_LEV  = 6'd8;
	localparam logic [5:0] OP_LI   = 6'd9;
	localparam logic [5:0] OP_LC   = 6'd10;
	localparam logic [5:0] OP_SI   = 6'd11;
	localparam logic [5:0] OP_SC   = 6'd12;
	localparam logic [5:0] OP_PUSH = 6'd13;
	localparam logic [5:0] OP_OR   = 6'd14;
	localparam logic [5:0] OP_XOR  = 6'd15;
	localparam logic [5:0] OP_AND  = 6'd16;
	localparam logic [5:0] OP_EQ   = 6'd17;
	localparam logic [5:0] OP_NE   = 6'd18;
	localparam logic [5:0] OP_LT   = 6'd19;
	localparam logic [5:0] OP_GT   = 6'd20;
	localparam logic [5:0] OP_LE   = 6'd21;
	localparam logic [5:0] OP_GE   = 6'd22;
	localparam logic [5:0] OP_SHL  = 6'd23;
	localparam logic [5:0] OP_SHR  = 6'd24;
	localparam logic [5:0] OP_ADD  = 6'd25;
	localparam logic [5:0] OP_SUB  = 6'd26;
	localparam logic [5:0] OP_MUL  = 6'd27;
	localparam logic [5:0] OP_DIV  = 6'd28;
	localparam logic [5:0] OP_MOD  = 6'd29;
	localparam logic [5:0] OP_EXIT = 6'd37;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_EXIT  = 3'd1;
	localparam logic [2:0] ST_UNSUP = 3'd2;
	localparam logic [2:0] ST_DIV0  = 3'd3;
	localparam logic [2:0] ST_BAD   = 3'd4;

	localparam logic CFG_START_PC  = 1'b0;
	localparam logic CFG_STACK_TOP = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_READ1,
		S_READ2,
		S_DIV,
		S_DONE
	} seq_state_t;

endpackage
`default_nettype wire

FILE: design/svm_div.sv
// Iterative signed divider for the stack machine core, one quotient bit a cycle.
// Truncates toward zero; depends on nothing but its ports.
`default_nettype none
module svm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [31:0]      quot,
	output logic [31:0]      rem
);
	logic        busy_q, done_q, neg_q_q, neg_r_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q, den_q;
	logic [32:0] sh;
	logic        ge;

	assign sh = {rem_q[31:0], quo_q[31]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			quo_q   <= num[31] ? (~num + 32'd1) : num;
			den_q   <= den[31] ? (~den + 32'd1) : den;
			neg_q_q <= num[31] ^ den[31];
			neg_r_q <= num[31];
		end else if (busy_q) begin
			rem_q <= ge ? (sh - {1'b0, den_q}) : sh;
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q_q ? (~quo_q + 32'd1) : quo_q;
	assign rem  = neg_r_q ? (~rem_q[31:0] + 32'd1) : rem_q[31:0];
endmodule
`default_nettype wire

FILE: design/stack_vm_execute_core_top.sv
// Execution core of a c4-style stack machine: sequencer, state and word memory.
// Depends on svm_pkg and svm_div.
//
//  channel | signals                                        | direction
//  in      | in_valid/in_ready, action, opcode, operand,    | into block
//          | preload_address                                |
//  out     | out_valid/out_ready, next_pc, acc, status,     | out of block
//          | exit_value                                     |
//  cfg     | cfg_we, cfg_index, cfg_data                    | into block
//
// out_valid rises when the sequencer reaches S_DONE: from S_ISSUE for preload, halted
// and register-only ops, via S_READ1 for one memory read (LI, LC, SI, EXIT, ALU), via
// S_READ1 and S_READ2 for LEV and SC (two dependent reads on the single read port), via
// S_READ1 and S_DIV for DIV and MOD (32-step divider). One item is in flight at a time;
// in_ready is high only in idle. Reset clears control and machine state, not the memory.
`default_nettype none
module stack_vm_execute_core_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [5:0]         opcode,
	input  wire logic signed [31:0] operand,
	input  wire logic [15:0]        preload_address,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             next_pc,
	output logic signed [31:0]      acc,
	output logic [2:0]              status,
	output logic signed [31:0]      exit_value,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [16:0]        cfg_data
);
	import svm_pkg::*;

	seq_state_t state_q, state_d;

	// Architectural state
	logic [15:0] pc_q, pc_d;
	logic [31:0] ax_q, ax_d;
	logic [16:0] sp_q, sp_d, bp_q, bp_d;
	logic [2:0]  halt_q, halt_d, status_q, status_d;
	logic [31:0] exit_q, exit_d;
	logic [31:0] a_q, a_d;

	// Captured item
	logic        act_q;
	logic [5:0]  op_q;
	logic [31:0] opnd_q;
	logic [MEM_AW-1:0] paddr_q;

	// Word memory, one port each for read and write
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rdata_q;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_wa, mem_ra;
	logic [31:0]       mem_wd;

	logic        div_start, div_done;
	logic [31:0] div_quot, div_rem;

	// Shared address and ALU terms
	logic [15:0] npc1, npc2;
	logic [16:0] sp_m4, sp_p4;
	logic [17:0] bp_p4;
	logic        push_ok, sp_word_ok, bp_word_ok, tgt_ok;
	logic signed [35:0] op4, ent_ns, adj_ns;
	logic [31:0] alu, lc_word, sc_mask, sc_data;
	logic [4:0]  lc_sh, sc_sh;
	logic [2:0]  fault;

	assign npc1       = pc_q + 16'd1;
	assign npc2       = pc_q + 16'd2;
	assign sp_m4      = sp_q - 17'd4;
	assign sp_p4      = sp_q + 17'd4;
	assign bp_p4      = {1'b0, bp_q} + 18'd4;
	assign push_ok    = (sp_q >= 17'd4) && (sp_q[1:0] == 2'b00) && (sp_q <= 17'd65536);
	assign sp_word_ok = (sp_q[1:0] == 2'b00) && !sp_q[16];
	assign bp_word_ok = (bp_q[1:0] == 2'b00) && !bp_q[16];
	assign tgt_ok     = (opnd_q[31:16] == 16'd0);
	assign op4        = {{2{opnd_q[31]}}, opnd_q, 2'b00};
	assign ent_ns     = $signed({19'd0, sp_q}) - 36'sd4 - op4;
	assign adj_ns     = $signed({19'd0, sp_q}) + op4;

	assign lc_sh   = {ax_q[1:0], 3'b000};
	assign lc_word = rdata_q >> lc_sh;
	assign sc_sh   = {a_q[1:0], 3'b000};
	assign sc_mask = 32'h0000_00FF << sc_sh;
	assign sc_data = (rdata_q & ~sc_mask) | ({24'd0, ax_q[7:0]} << sc_sh);

	// Shared ALU: first operand popped from the stack, second the accumulator
	always_comb begin
		alu = ax_q;
		unique case (op_q)
			OP_OR:   alu = rdata_q | ax_q;
			OP_XOR:  alu = rdata_q ^ ax_q;
			OP_AND:  alu = rdata_q & ax_q;
			OP_EQ:   alu = {31'd0, rdata_q == ax_q};
			OP_NE:   alu = {31'd0, rdata_q != ax_q};
			OP_LT:   alu = {31'd0, $signed(rdata_q) < $signed(ax_q)};
			OP_GT:   alu = {31'd0, $signed(ax_q) < $signed(rdata_q)};
			OP_LE:   alu = {31'd0, !($signed(ax_q) < $signed(rdata_q))};
			OP_GE:   alu = {31'd0, !($signed(rdata_q) < $signed(ax_q))};
			OP_SHL:  alu = rdata_q << ax_q[4:0];
			OP_SHR:  alu = $unsigned($signed(rdata_q) >>> ax_q[4:0]);
			OP_ADD:  alu = rdata_q + ax_q;
			OP_SUB:  alu = rdata_q - ax_q;
			OP_MUL:  alu = rdata_q * ax_q;
			default: alu = ax_q;
		endcase
	end

	// Sequencer: next state, state updates, memory control
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		ax_d      = ax_q;
		sp_d      = sp_q;
		bp_d      = bp_q;
		halt_d    = halt_q;
		status_d  = status_q;
		exit_d    = exit_q;
		a_d       = a_q;
		mem_we    = 1'b0;
		mem_wa    = sp_m4[MEM_AW+1:2];
		mem_wd    = ax_q;
		mem_ra    = sp_q[MEM_AW+1:2];
		div_start = 1'b0;
		fault     = ST_RUN;
		unique case (state_q)
			S_IDLE: begin
				// Configuration lands only while idle
				if (cfg_we) begin
					if (cfg_index == CFG_START_PC) begin
						pc_d = cfg_data[15:0];
					end else begin
						sp_d = cfg_data;
						bp_d = cfg_data;
					end
				end
				if (in_valid) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_d  = S_DONE;
				status_d = ST_RUN;
				exit_d   = '0;
				if (act_q) begin
					mem_we   = 1'b1;
					mem_wa   = paddr_q;
					mem_wd   = opnd_q;
					status_d = halt_q;
				end else if (halt_q != ST_RUN) begin
					status_d = halt_q;
				end else begin
					unique case (op_q)
						OP_LEA: begin
							ax_d = {15'd0, bp_q} + {opnd_q[29:0], 2'b00};
							pc_d = npc2;
						end
						OP_IMM: begin
							ax_d = opnd_q;
							pc_d = npc2;
						end
						OP_JMP: begin
							if (tgt_ok) pc_d = opnd_q[15:0];
							else fault = ST_BAD;
						end
						OP_CALL: begin
							if (tgt_ok && push_ok) begin
								mem_we = 1'b1;
								mem_wd = {16'd0, npc2};
								sp_d   = sp_m4;
								pc_d   = opnd_q[15:0];
							end else begin
								fault = ST_BAD;
							end
						end
						OP_JZ, OP_JNZ: begin
							if ((ax_q == 32'd0) == (op_q == OP_JZ)) begin
								if (tgt_ok) pc_d = opnd_q[15:0];
								else fault = ST_BAD;
							end else begin
								pc_d = npc2;
							end
						end
						OP_ENT: begin
							if (push_ok && !ent_ns[35] && ent_ns <= 36'sd65536) begin
								mem_we = 1'b1;
								mem_wd = {15'd0, bp_q};
								bp_d   = sp_m4;
								sp_d   = ent_ns[16:0];
								pc_d   = npc2;
							end else begin
								fault = ST_BAD;
							end
						end
						OP_ADJ: begin
							if (!adj_ns[35] && adj_ns <= 36'sd65536) begin
								sp_d = adj_ns[16:0];
								pc_d = npc2;
							end else begin
								fault = ST_BAD;
							end
						end
						OP_LEV: begin
							mem_ra = bp_q[MEM_AW+1:2];
							if (bp_word_ok) state_d = S_READ1;
							else fault = ST_BAD;
						end
						OP_LI: begin
							mem_ra = ax_q[MEM_AW+1:2];
							if (ax_q[1:0] == 2'b00 && ax_q[31:16] == 16'd0) state_d = S_READ1;
							else fault = ST_BAD;
						end
						OP_LC: begin
							mem_ra = ax_q[MEM_AW+1:2];
							if (ax_q[31:16] == 16'd0) state_d = S_READ1;
							else fault = ST_BAD;
						end
						OP_PUSH: begin
							if (push_ok) begin
								mem_we = 1'b1;
								sp_d   = sp_m4;
								pc_d   = npc1;
							end else begin
								fault = ST_BAD;
							end
						end
						OP_SI, OP_SC, OP_EXIT, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE,
						OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB,
						OP_MUL, OP_DIV, OP_MOD: begin
							// Pop from the stack top first
							if (sp_word_ok) state_d = S_READ1;
							else fault = ST_BAD;
						end
						default: fault = ST_UNSUP;
					endcase
				end
			end
			S_READ1: begin
				state_d = S_DONE;
				unique case (op_q)
					OP_LEV: begin
						a_d    = rdata_q;
						mem_ra = bp_p4[MEM_AW+1:2];
						if (bp_p4[17:16] == 2'b00) state_d = S_READ2;
						else fault = ST_BAD;
					end
					OP_LI: begin
						ax_d = rdata_q;
						pc_d = npc1;
					end
					OP_LC: begin
						ax_d = {{24{lc_word[7]}}, lc_word[7:0]};
						pc_d = npc1;
					end
					OP_SI: begin
						if (rdata_q[1:0] == 2'b00 && rdata_q[31:16] == 16'd0) begin
							mem_we = 1'b1;
							mem_wa = rdata_q[MEM_AW+1:2];
							sp_d   = sp_p4;
							pc_d   = npc1;
						end else begin
							fault = ST_BAD;
						end
					end
					OP_SC: begin
						a_d    = rdata_q;
						mem_ra = rdata_q[MEM_AW+1:2];
						if (rdata_q[31:16] == 16'd0) state_d = S_READ2;
						else fault = ST_BAD;
					end
					OP_EXIT: begin
						exit_d   = rdata_q;
						status_d = ST_EXIT;
						halt_d   = ST_EXIT;
					end
					OP_DIV, OP_MOD: begin
						if (ax_q == 32'd0) begin
							fault = ST_DIV0;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					default: begin
						ax_d = alu;
						sp_d = sp_p4;
						pc_d = npc1;
					end
				endcase
			end
			S_READ2: begin
				state_d = S_DONE;
				if (op_q == OP_LEV) begin
					// Saved frame pointer in a_q, return pc in rdata_q
					if (a_q[31:17] == 15'd0 && (!a_q[16] || a_q[15:0] == 16'd0) &&
					    rdata_q[31:16] == 16'd0) begin
						bp_d = a_q[16:0];
						pc_d = rdata_q[15:0];
						sp_d = bp_p4[16:0] + 17'd4;
					end else begin
						fault = ST_BAD;
					end
				end else begin
					mem_we = 1'b1;
					mem_wa = a_q[MEM_AW+1:2];
					mem_wd = sc_data;
					ax_d   = {{24{ax_q[7]}}, ax_q[7:0]};
					sp_d   = sp_p4;
					pc_d   = npc1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					ax_d    = (op_q == OP_DIV) ? div_quot : div_rem;
					sp_d    = sp_p4;
					pc_d    = npc1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// A fault leaves everything but the halt and status codes in place
		if (fault != ST_RUN) begin
			halt_d   = fault;
			status_d = fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pc_q     <= '0;
			ax_q     <= '0;
			sp_q     <= 17'd65536;
			bp_q     <= 17'd65536;
			halt_q   <= ST_RUN;
			status_q <= ST_RUN;
			exit_q   <= '0;
		end else begin
			state_q  <= state_d;
			pc_q     <= pc_d;
			ax_q     <= ax_d;
			sp_q     <= sp_d;
			bp_q     <= bp_d;
			halt_q   <= halt_d;
			status_q <= status_d;
			exit_q   <= exit_d;
		end
	end

	// Hold the item and the popped word
	always_ff @(posedge clk) begin
		a_q <= a_d;
		if (in_valid && in_ready) begin
			act_q   <= action;
			op_q    <= opcode;
			opnd_q  <= operand;
			paddr_q <= preload_address[MEM_AW+1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	svm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rdata_q),
		.den    (ax_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_DONE);
	assign next_pc    = pc_q;
	assign acc        = ax_q;
	assign status     = status_q;
	assign exit_value = exit_q;
endmodule
`default_nettype wire

FILE: design/svm_chk.sv
// Port-level checker for the stack machine core, bound to the top level.
// Depends on svm_pkg for status codes.
`default_nettype none
module svm_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] next_pc,
	input wire logic [31:0] acc,
	input wire logic [2:0]  status,
	input wire logic [31:0] exit_value
);
	import svm_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while result pending");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready stayed high after transfer");

	a_exit_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_EXIT |-> exit_value == 32'd0)
		else $error("exit value without exit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(acc) &&
		$stable(status)) else $error("stalled result changed");
endmodule

bind stack_vm_execute_core_top svm_chk u_svm_chk (.*);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the stack machine execution core.
// Depends on svm_pkg and stack_vm_execute_core_top; holds its own predictor of the core.
// Runs a directed table, random instruction streams per register setting, then one halt.
`default_nettype none
module testbench;
	import svm_pkg::*;

	localparam int IDLE_LIMIT = 5000;   // cycles with no transfer before giving up
	localparam int MEM_BYTES  = MEM_WORDS * 4;

	typedef struct {
		logic        action;
		logic [5:0]  opcode;
		logic [31:0] operand;
		logic [15:0] addr;
	} vm_item_t;

	typedef struct {
		logic [15:0] next_pc;
		logic [31:0] acc;
		logic [2:0]  status;
		logic [31:0] exit_value;
	} vm_result_t;

	typedef struct {
		vm_item_t   it;
		bit         typed;
		vm_result_t res;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, action;
	logic [5:0] opcode;
	logic signed [31:0] operand;
	logic [15:0] preload_address;
	logic out_valid, out_ready;
	logic [15:0] next_pc;
	logic signed [31:0] acc, exit_value;
	logic [2:0] status;
	logic cfg_we, cfg_index;
	logic [16:0] cfg_data;

	// predicted machine state
	logic [15:0] pc_q;
	logic [31:0] acc_q, sp_q, bp_q;
	logic [2:0]  halt_q;
	logic [31:0] mem_q [MEM_WORDS];
	bit          written_q [MEM_WORDS];

	vm_result_t expected_q [$];
	int errors, results_seen, instr_sent, preloads_sent, settings_done, idle_cycles;
	bit calm;

	stack_vm_execute_core_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .opcode(opcode),
		.operand(operand), .preload_address(preload_address),
		.out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc), .acc(acc),
		.status(status), .exit_value(exit_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit word_ok(logic [31:0] a);
		return a[1:0] == 2'b00 && a < MEM_BYTES;
	endfunction

	function automatic bit push_ok(logic [31:0] sp);
		return sp >= 4 && word_ok(sp - 4);
	endfunction

	// Read a predicted word; note the first word read that was never written.
	function automatic logic [31:0] peek(int idx, inout int miss);
		if (!written_q[idx] && miss < 0)
			miss = idx;
		return mem_q[idx];
	endfunction

	// Work out the result of one item. With commit low nothing is changed, so the
	// generator can ask what an item would do and which unwritten word it would read.
	function automatic void execute_vm(vm_item_t it, bit commit, output vm_result_t r,
			output int miss);
		logic [15:0] pc, npc, npc2;
		logic [31:0] ax, sp, bp, a, t, opnd, exitv, wdata;
		logic [2:0] st;
		logic [4:0] sh;
		longint ns;
		int widx;
		bit wen;
		miss = -1;
		wen = 0; widx = 0; wdata = '0; a = '0; t = '0; exitv = '0;
		pc = pc_q; ax = acc_q; sp = sp_q; bp = bp_q; opnd = it.operand; st = ST_RUN;
		npc = pc + 16'd1;
		npc2 = pc + 16'd2;
		if (it.action) begin
			wen = 1; widx = it.addr[15:2]; wdata = opnd; st = halt_q;
		end else if (halt_q != ST_RUN) begin
			st = halt_q;
		end else begin
			case (it.opcode)
				OP_LEA: begin ax = bp + (opnd << 2); npc = npc2; end
				OP_IMM: begin ax = opnd; npc = npc2; end
				OP_JMP: begin
					if (opnd >= 65536) st = ST_BAD; else npc = opnd[15:0];
				end
				OP_CALL: begin
					if (opnd >= 65536 || !push_ok(sp)) st = ST_BAD;
					else begin
						sp = sp - 4; wen = 1; widx = sp >> 2; wdata = {16'd0, npc2};
						npc = opnd[15:0];
					end
				end
				OP_JZ, OP_JNZ: begin
					if ((ax == 0) == (it.opcode == OP_JZ)) begin
						if (opnd >= 65536) st = ST_BAD; else npc = opnd[15:0];
					end else npc = npc2;
				end
				OP_ENT: begin
					ns = longint'(sp) - 4 - 4 * longint'($signed(opnd));
					if (!push_ok(sp) || ns < 0 || ns > MEM_BYTES) st = ST_BAD;
					else begin
						sp = sp - 4; wen = 1; widx = sp >> 2; wdata = bp;
						bp = sp; sp = ns[31:0]; npc = npc2;
					end
				end
				OP_ADJ: begin
					ns = longint'(sp) + 4 * longint'($signed(opnd));
					if (ns < 0 || ns > MEM_BYTES) st = ST_BAD;
					else begin sp = ns[31:0]; npc = npc2; end
				end
				OP_LEV: begin
					sp = bp;
					if (!word_ok(sp)) st = ST_BAD;
					else begin
						a = peek(sp >> 2, miss); sp = sp + 4;
						if (!word_ok(sp)) st = ST_BAD;
						else begin
							t = peek(sp >> 2, miss); sp = sp + 4;
							if (a > MEM_BYTES || t >= 65536) st = ST_BAD;
							else begin bp = a; npc = t[15:0]; end
						end
					end
				end
				OP_LI: begin
					if (!word_ok(ax)) st = ST_BAD; else ax = peek(ax >> 2, miss);
				end
				OP_LC: begin
					if (ax >= MEM_BYTES) st = ST_BAD;
					else begin
						t = peek(ax >> 2, miss) >> (ax[1:0] * 8);
						ax = {{24{t[7]}}, t[7:0]};
					end
				end
				OP_SI, OP_SC: begin
					if (!word_ok(sp)) st = ST_BAD;
					else begin
						a = peek(sp >> 2, miss); sp = sp + 4;
						if (it.opcode == OP_SI) begin
							if (!word_ok(a)) st = ST_BAD;
							else begin wen = 1; widx = a >> 2; wdata = ax; end
						end else if (a >= MEM_BYTES) st = ST_BAD;
						else begin
							// merge the low byte of acc into the addressed word
							sh = {a[1:0], 3'b000};
							t = peek(a >> 2, miss);
							wen = 1; widx = a >> 2;
							wdata = (t & ~(32'hff << sh)) | ({24'd0, ax[7:0]} << sh);
							ax = {{24{ax[7]}}, ax[7:0]};
						end
					end
				end
				OP_PUSH: begin
					if (!push_ok(sp)) st = ST_BAD;
					else begin sp = sp - 4; wen = 1; widx = sp >> 2; wdata = ax; end
				end
				OP_EXIT: begin
					if (!word_ok(sp)) st = ST_BAD;
					else begin st = ST_EXIT; exitv = peek(sp >> 2, miss); end
				end
				default: begin
					if (it.opcode < OP_OR || it.opcode > OP_MOD) st = ST_UNSUP;
					else if (!word_ok(sp)) st = ST_BAD;
					else begin
						a = peek(sp >> 2, miss); sp = sp + 4;
						case (it.opcode)
							OP_OR:  ax = a | ax;
							OP_XOR: ax = a ^ ax;
							OP_AND: ax = a & ax;
							OP_EQ:  ax = {31'd0, a == ax};
							OP_NE:  ax = {31'd0, a != ax};
							OP_LT:  ax = {31'd0, $signed(a) < $signed(ax)};
							OP_GT:  ax = {31'd0, $signed(a) > $signed(ax)};
							OP_LE:  ax = {31'd0, $signed(a) <= $signed(ax)};
							OP_GE:  ax = {31'd0, $signed(a) >= $signed(ax)};
							OP_SHL: ax = a << ax[4:0];
							OP_SHR: ax = $signed(a) >>> ax[4:0];
							OP_ADD: ax = a + ax;
							OP_SUB: ax = a - ax;
							OP_MUL: ax = a * ax;
							default: begin
								if (ax == 0) st = ST_DIV0;
								else if (a == 32'h8000_0000 && ax == 32'hffff_ffff)
									ax = (it.opcode == OP_DIV) ? a : 32'd0;
								else if (it.opcode == OP_DIV)
									ax = $signed(a) / $signed(ax);
								else
									ax = $signed(a) % $signed(ax);
							end
						endcase
					end
				end
			endcase
		end
		r.status = st;
		r.exit_value = exitv;
		if (!it.action && st == ST_RUN) begin
			r.next_pc = npc; r.acc = ax;
		end else begin
			r.next_pc = pc_q; r.acc = acc_q;
		end
		if (commit) begin
			if (wen && (it.action || st == ST_RUN)) begin
				mem_q[widx] = wdata; written_q[widx] = 1;
			end
			if (!it.action) begin
				if (st == ST_RUN) begin
					pc_q = npc; acc_q = ax; sp_q = sp; bp_q = bp;
				end else halt_q = st;
			end
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Drive one item and hold it until the transfer. Valid is lowered only for a gap,
	// so back-to-back items never see two assignments in one step.
	task automatic drive_item(vm_item_t it);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		opcode <= it.opcode;
		operand <= it.operand;
		preload_address <= it.addr;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_vm(vm_item_t it, bit typed = 0, vm_result_t typed_res = '{default: '0});
		vm_result_t r;
		int miss;
		execute_vm(it, 1, r, miss);
		expected_q.push_back(typed ? typed_res : r);
		if (it.action) preloads_sent++; else instr_sent++;
		drive_item(it);
	endtask

	function automatic logic [31:0] preload_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, MEM_WORDS - 1) * 4;   // looks like an address
			1: return $urandom_range(0, 65535);               // looks like a pc
			default: return $urandom;
		endcase
	endfunction

	// Write any never-written word that the item would read, then send it.
	task automatic fill_and_send(vm_item_t it, bit typed = 0,
			vm_result_t typed_res = '{default: '0});
		vm_result_t r;
		vm_item_t pre;
		int miss;
		forever begin
			execute_vm(it, 0, r, miss);
			if (miss < 0) break;
			pre = '{action: 1'b1, opcode: 6'($urandom), operand: preload_word(),
				addr: 16'(miss * 4) | 16'($urandom_range(0, 3))};
			send_vm(pre);
		end
		send_vm(it, typed, typed_res);
	endtask

	function automatic vm_item_t exec_of(logic [5:0] op, logic [31:0] opnd);
		return '{action: 1'b0, opcode: op, operand: opnd, addr: 16'($urandom)};
	endfunction

	function automatic vm_item_t random_candidate();
		int r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = $urandom;
		if (r < 8)
			return '{action: 1'b1, opcode: 6'($urandom), operand: v, addr: 16'($urandom)};
		if (r < 22) begin
			case ($urandom_range(0, 4))
				0: v = sp_q - 4 * $urandom_range(0, 8);
				1: v = $urandom_range(0, MEM_BYTES - 1);
				2: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				3: v = $urandom_range(0, 40) - 8;
				default: ;
			endcase
			return exec_of(OP_IMM, v);
		end
		if (r < 30) return exec_of(OP_PUSH, v);
		if (r < 34) return exec_of(OP_LEA, 32'($signed($urandom_range(0, 16)) - 8));
		if (r < 40) return exec_of(6'($urandom_range(OP_JMP, OP_JNZ)), $urandom_range(0, 65535));
		if (r < 45) return exec_of(OP_ENT, $urandom_range(0, 6));
		if (r < 49) return exec_of(OP_ADJ, 32'($signed($urandom_range(0, 8)) - 2));
		if (r < 54) return exec_of(OP_LEV, v);
		if (r < 62) return exec_of(6'($urandom_range(OP_LI, OP_SC)), v);
		return exec_of(6'($urandom_range(OP_OR, OP_MOD)), v);
	endfunction

	// Pick an item that keeps the machine running; a halt is kept for the end.
	task automatic send_running();
		vm_item_t it;
		vm_result_t r;
		vm_item_t pre;
		int miss;
		for (int k = 0; k < 10; k++) begin
			it = random_candidate();
			forever begin
				execute_vm(it, 0, r, miss);
				if (miss < 0) break;
				pre = '{action: 1'b1, opcode: 6'($urandom), operand: preload_word(),
					addr: 16'(miss * 4)};
				send_vm(pre);
			end
			if (r.status == ST_RUN) begin
				send_vm(it);
				return;
			end
		end
		send_vm(exec_of(OP_IMM, $urandom));
	endtask

	// Drain, then load both registers back to back while the core is idle.
	task automatic set_registers(logic [15:0] start_pc, logic [16:0] stack_top);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_START_PC;
		cfg_data <= {1'b0, start_pc};
		@(posedge clk);
		cfg_index <= CFG_STACK_TOP;
		cfg_data <= stack_top;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		pc_q = start_pc;
		sp_q = {15'd0, stack_top};
		bp_q = {15'd0, stack_top};
		settings_done++;
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch on result %0d: %s got %h expected %h", results_seen, field, got,
			want);
	endtask

	// Check each result transfer against the oldest expectation; watch for a hang.
	always @(posedge clk) begin
		vm_result_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transfer for %0d cycles", IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("result %0d arrived with nothing expected", results_seen);
				end else begin
					e = expected_q.pop_front();
					if (next_pc !== e.next_pc) report_mismatch("next_pc", next_pc, e.next_pc);
					if (acc !== e.acc) report_mismatch("acc", acc, e.acc);
					if (status !== e.status) report_mismatch("status", status, e.status);
					if (exit_value !== e.exit_value)
						report_mismatch("exit_value", exit_value, e.exit_value);
				end
			end
		end
	end

	// Receiver: random stalls, none while calm.
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, calm ? 40 : 8)) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		plan_row_t plan [$];
		plan_row_t row;
		int target, kind;
		logic [15:0] spc;
		logic [16:0] stop;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		opcode = '0;
		operand = '0;
		preload_address = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_PC;
		cfg_data = '0;
		calm = 0;
		errors = 0; results_seen = 0; instr_sent = 0; preloads_sent = 0;
		settings_done = 0; idle_cycles = 0;
		pc_q = '0; acc_q = '0; sp_q = 32'd65536; bp_q = 32'd65536; halt_q = ST_RUN;
		foreach (mem_q[i]) begin
			mem_q[i] = '0;
			written_q[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, wrap, the most negative value over -1, a byte
		// store, then a call/enter/leave frame and jumps that wrap the pc.
		set_registers(16'd16, 17'd65536);
		row = '{it: exec_of(OP_IMM, 32'h7fff_ffff), typed: 1,
			res: '{next_pc: 16'd18, acc: 32'h7fff_ffff, status: ST_RUN, exit_value: 0}};
		plan.push_back(row);
		row.typed = 0;
		row.it = exec_of(OP_PUSH, 32'hffff_ffff);  plan.push_back(row);
		row = '{it: exec_of(OP_IMM, 32'h8000_0000), typed: 1,
			res: '{next_pc: 16'd21, acc: 32'h8000_0000, status: ST_RUN, exit_value: 0}};
		plan.push_back(row);
		row.typed = 0;
		row.it = exec_of(OP_ADD, 32'h0);           plan.push_back(row);
		row.it = exec_of(OP_IMM, 32'h8000_0000);   plan.push_back(row);
		row.it = exec_of(OP_PUSH, 32'h0);          plan.push_back(row);
		row.it = exec_of(OP_IMM, 32'hffff_ffff);   plan.push_back(row);
		row.it = exec_of(OP_DIV, 32'h0);           plan.push_back(row);
		row.it = exec_of(OP_PUSH, 32'h0);          plan.push_back(row);
		row.it = exec_of(OP_IMM, 32'hffff_ffff);   plan.push_back(row);
		row.it = exec_of(OP_MOD, 32'h0);           plan.push_back(row);
		row.it = exec_of(OP_PUSH, 32'h0);          plan.push_back(row);
		row.it = exec_of(OP_LEA, 32'hffff_ffff);   plan.push_back(row);
		row.it = exec_of(OP_LI, 32'h0);            plan.push_back(row);
		row.it = exec_of(OP_IMM, 32'd65533);       plan.push_back(row);
		row.it = exec_of(OP_LC, 32'h0);            plan.push_back(row);
		row.it = exec_of(OP_IMM, 32'd65532);       plan.push_back(row);
		row.it = exec_of(OP_PUSH, 32'h0);          plan.push_back(row);
		row.it = exec_of(OP_IMM, 32'h0000_80ab);   plan.push_back(row);
		row.it = exec_of(OP_SC, 32'h0);            plan.push_back(row);
		row.it = exec_of(OP_CALL, 32'd200);        plan.push_back(row);
		row.it = exec_of(OP_ENT, 32'd2);           plan.push_back(row);
		row.it = exec_of(OP_ADJ, 32'd2);           plan.push_back(row);
		row.it = exec_of(OP_LEV, 32'h0);           plan.push_back(row);
		row.it = exec_of(OP_JNZ, 32'd65535);       plan.push_back(row);
		row.it = exec_of(OP_JZ, 32'd7);            plan.push_back(row);
		row.it = exec_of(OP_JMP, 32'd0);           plan.push_back(row);
		foreach (plan[i])
			fill_and_send(plan[i].it, plan[i].typed, plan[i].res);

		// Random streams, one register setting per phase, extremes first.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin spc = 16'd0;     stop = 17'd65536; end
				1: begin spc = 16'd65535; stop = 17'd256;   end
				2: begin spc = 16'($urandom); stop = 17'd0; end
				3: begin spc = 16'($urandom); stop = 17'd16; end
				default: begin
					spc = 16'($urandom);
					stop = 17'($urandom_range(64, MEM_WORDS) * 4);
				end
			endcase
			set_registers(spc, stop);
			calm = (p == 1);
			target = instr_sent + preloads_sent + 280;
			while (instr_sent + preloads_sent < target)
				send_running();
			calm = 0;
		end

		// Halt the core one way, then check that it stays halted but preloads land.
		set_registers(16'($urandom), 17'd65536);
		kind = $urandom_range(0, 3);
		case (kind)
			0: begin
				fill_and_send(exec_of(OP_PUSH, $urandom));
				fill_and_send(exec_of(OP_IMM, 32'd0));
				fill_and_send(exec_of(OP_DIV, $urandom));
			end
			1: begin
				do spc[5:0] = 6'($urandom_range(30, 63)); while (spc[5:0] == OP_EXIT);
				fill_and_send(exec_of(spc[5:0], $urandom));
			end
			2: begin
				fill_and_send(exec_of(OP_IMM, $urandom));
				fill_and_send(exec_of(OP_PUSH, $urandom));
				fill_and_send(exec_of(OP_EXIT, $urandom));
			end
			default: fill_and_send(exec_of(OP_JMP, 32'h0001_0000 | $urandom));
		endcase
		for (int k = 0; k < 16; k++)
			fill_and_send('{action: 1'($urandom), opcode: 6'($urandom), operand: $urandom,
				addr: 16'($urandom)});

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d instructions and %0d preloads over %0d register settings",
			instr_sent, preloads_sent, settings_done);
		$display("checked %0d results, final halt code %0d, %0d mismatches",
			results_seen, halt_q, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
